FILE: design/clcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD sequencer package
// Shared types, constants and tables for the 4-bit LCD command sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

   localparam logic [7:0] COLUMNS = 8'd16;
   localparam int         QDEPTH  = 4;
   localparam int         QPTR_W  = $clog2(QDEPTH);
   localparam int         DIGITS  = 5;

   localparam logic [2:0] ACT_INIT    = 3'd0;
   localparam logic [2:0] ACT_DISPLAY = 3'd1;
   localparam logic [2:0] ACT_CURSOR  = 3'd2;
   localparam logic [2:0] ACT_BLINK   = 3'd3;
   localparam logic [2:0] ACT_CLEAR   = 3'd4;
   localparam logic [2:0] ACT_CHAR    = 3'd5;
   localparam logic [2:0] ACT_GOTO    = 3'd6;
   localparam logic [2:0] ACT_NUMBER  = 3'd7;

   localparam logic [1:0] OP_POLL = 2'd0;
   localparam logic [1:0] OP_BARE = 2'd1;
   localparam logic [1:0] OP_NIB  = 2'd2;

   localparam logic [1:0] PAUSE_NONE  = 2'd0;
   localparam logic [1:0] PAUSE_POWER = 2'd1;
   localparam logic [1:0] PAUSE_WAKE  = 2'd2;
   localparam logic [1:0] PAUSE_SHORT = 2'd3;

   localparam logic       KIND_WRITE = 1'b0;
   localparam logic       KIND_POLL  = 1'b1;

   localparam logic [2:0] DISP_ON     = 3'h4;
   localparam logic [2:0] DISP_CURSOR = 3'h2;
   localparam logic [2:0] DISP_BLINK  = 3'h1;

   localparam logic [7:0] CMD_DISPLAY  = 8'h08;
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_ENTRY    = 8'h06;
   localparam logic [7:0] CMD_FUNCTION = 8'h28;
   localparam logic [7:0] CMD_ADDRESS  = 8'h80;
   localparam logic [7:0] ROW1_OFFSET  = 8'h40;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;

   // Reciprocal of ten, exact for values below 81920.
   localparam logic [31:0] RECIP_TEN   = 32'd52429;
   localparam int          RECIP_SHIFT = 19;

   typedef struct packed {
      logic [1:0] op;
      logic       rs;
      logic [7:0] data;
      logic [1:0] pause_sel;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [19:0] pause_value(input logic [1:0] sel);
      logic [19:0] v;
      unique case (sel)
         PAUSE_POWER: v = 20'd800000;
         PAUSE_WAKE:  v = 20'd67200;
         PAUSE_SHORT: v = 20'd2400;
         default:     v = 20'd0;
      endcase
      return v;
   endfunction

   function automatic entry_type make_entry(input logic [1:0] op, input logic rs,
                                            input logic [7:0] data,
                                            input logic [1:0] pause_sel,
                                            input logic last);
      entry_type e;
      e.op        = op;
      e.rs        = rs;
      e.data      = data;
      e.pause_sel = pause_sel;
      e.last      = last;
      return e;
   endfunction

   function automatic entry_type init_entry(input logic [2:0] step);
      entry_type e;
      unique case (step)
         3'd0:    e = make_entry(OP_NIB, 1'b0, 8'h03, PAUSE_POWER, 1'b0);
         3'd1:    e = make_entry(OP_NIB, 1'b0, 8'h03, PAUSE_WAKE, 1'b0);
         3'd2:    e = make_entry(OP_NIB, 1'b0, 8'h03, PAUSE_SHORT, 1'b0);
         3'd3:    e = make_entry(OP_NIB, 1'b0, 8'h02, PAUSE_SHORT, 1'b0);
         3'd4:    e = make_entry(OP_BARE, 1'b0, CMD_FUNCTION, PAUSE_SHORT, 1'b0);
         3'd5:    e = make_entry(OP_POLL, 1'b0, CMD_DISPLAY | 8'(DISP_ON),
                                 PAUSE_NONE, 1'b0);
         3'd6:    e = make_entry(OP_POLL, 1'b0, CMD_CLEAR, PAUSE_NONE, 1'b0);
         default: e = make_entry(OP_POLL, 1'b0, CMD_ENTRY, PAUSE_NONE, 1'b1);
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

FILE: design/char_lcd_command_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD command sequencer
// Turns character LCD requests into 4-bit bus transfers: status polls and
// nibble writes with their leading pauses.
// ----------------------------------------------------------------------------
// Each entry goes through the entry queue and the back end's output register.
// Init entries are queued from the init state; a number without a minus sign
// first has its decimal digits (up to five) produced before its first digit.
// Throughput: one transfer per cycle while the sink takes them and the queue
// holds entries; a request has up to eighteen transfers. A new request is taken
// once the front end has queued all entries of the previous one and the queue is
// not full. Synchronous reset empties the queue and clears the display bits.
module char_lcd_command_sequencer_top
   import clcd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_action,
   input  wire logic               req_flag_on,
   input  wire logic [7:0]         req_char_code,
   input  wire logic [7:0]         req_column,
   input  wire logic [7:0]         req_row,
   input  wire logic signed [15:0] req_number,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_kind,
   output logic                    rsp_reg_select,
   output logic [3:0]              rsp_nibble,
   output logic [19:0]             rsp_pause_cycles,
   output logic                    rsp_last
);

   q_push_type   q_push;
   q_status_type q_status;
   entry_type    q_head;
   logic         q_pop;

   clcd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_flag_on   (req_flag_on),
      .req_char_code (req_char_code),
      .req_column    (req_column),
      .req_row       (req_row),
      .req_number    (req_number),
      .q_status      (q_status),
      .q_push        (q_push)
   );

   clcd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_status (q_status),
      .q_head   (q_head)
   );

   clcd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_reg_select   (rsp_reg_select),
      .rsp_nibble       (rsp_nibble),
      .rsp_pause_cycles (rsp_pause_cycles),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

FILE: design/clcd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD sequencer front end
// Accepts requests, keeps the display control bits and breaks each request
// into byte entries, converting numbers to decimal one digit per cycle.
// ----------------------------------------------------------------------------
module clcd_front
   import clcd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [2:0]        req_action,
   input  wire logic              req_flag_on,
   input  wire logic [7:0]        req_char_code,
   input  wire logic [7:0]        req_column,
   input  wire logic [7:0]        req_row,
   input  wire logic signed [15:0] req_number,
   input  wire q_status_type      q_status,
   output q_push_type             q_push
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_INIT = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  step_ff, step_in;
   logic [2:0]  disp_ff, disp_in;
   logic [15:0] mag_ff, mag_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [3:0]  stack_ff [DIGITS];
   logic [3:0]  stack_in [DIGITS];

   logic        accept;
   logic [2:0]  ctrl_bit;
   logic [2:0]  ctrl_new;
   logic [31:0] prod;
   logic [12:0] quot;
   logic [15:0] quot10;
   logic [15:0] rem_w;
   logic [7:0]  goto_cmd;

   assign req_ready = (state_ff == ST_IDLE) && !q_status.full;
   assign accept    = req_valid && req_ready;

   assign prod   = 32'(mag_ff) * RECIP_TEN;
   assign quot   = prod[31:RECIP_SHIFT];
   assign quot10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
   assign rem_w  = mag_ff - quot10;

   assign goto_cmd = CMD_ADDRESS | (req_row[0] ? ROW1_OFFSET : 8'h00) | req_column;

   always_comb begin
      unique case (req_action)
         ACT_DISPLAY: ctrl_bit = DISP_ON;
         ACT_CURSOR:  ctrl_bit = DISP_CURSOR;
         default:     ctrl_bit = DISP_BLINK;
      endcase
      ctrl_new = req_flag_on ? (disp_ff | ctrl_bit) : (disp_ff & ~ctrl_bit);
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      disp_in  = disp_ff;
      mag_in   = mag_ff;
      cnt_in   = cnt_ff;
      for (int i = 0; i < DIGITS; i++) begin
         stack_in[i] = stack_ff[i];
      end
      q_push.valid = 1'b0;
      q_push.entry = make_entry(OP_POLL, 1'b0, 8'h00, PAUSE_NONE, 1'b0);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_INIT: begin
                     disp_in  = DISP_ON;
                     step_in  = 3'd0;
                     state_in = ST_INIT;
                  end
                  ACT_DISPLAY, ACT_CURSOR, ACT_BLINK: begin
                     disp_in      = ctrl_new;
                     q_push.valid = 1'b1;
                     q_push.entry = make_entry(OP_POLL, 1'b0,
                                               CMD_DISPLAY | 8'(ctrl_new),
                                               PAUSE_NONE, 1'b1);
                  end
                  ACT_CLEAR: begin
                     q_push.valid = 1'b1;
                     q_push.entry = make_entry(OP_POLL, 1'b0, CMD_CLEAR,
                                               PAUSE_NONE, 1'b1);
                  end
                  ACT_CHAR: begin
                     q_push.valid = 1'b1;
                     q_push.entry = make_entry(OP_POLL, 1'b1, req_char_code,
                                               PAUSE_NONE, 1'b1);
                  end
                  ACT_GOTO: begin
                     q_push.valid = (req_column < COLUMNS) && (req_row <= 8'd1);
                     q_push.entry = make_entry(OP_POLL, 1'b0, goto_cmd,
                                               PAUSE_NONE, 1'b1);
                  end
                  default: begin
                     q_push.valid = req_number[15];
                     q_push.entry = make_entry(OP_POLL, 1'b1, CHAR_MINUS,
                                               PAUSE_NONE, 1'b0);
                     mag_in   = req_number[15] ? 16'(-req_number) : req_number;
                     cnt_in   = 3'd0;
                     state_in = ST_DIV;
                  end
               endcase
            end
         end
         ST_INIT: begin
            if (!q_status.full) begin
               q_push.valid = 1'b1;
               q_push.entry = init_entry(step_ff);
               step_in      = step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            stack_in[0] = rem_w[3:0];
            for (int i = 1; i < DIGITS; i++) begin
               stack_in[i] = stack_ff[i-1];
            end
            mag_in = 16'(quot);
            cnt_in = cnt_ff + 3'd1;
            if ((quot == 13'd0) || (cnt_ff == 3'(DIGITS - 1))) begin
               state_in = ST_EMIT;
            end
         end
         default: begin
            if (!q_status.full) begin
               q_push.valid = 1'b1;
               q_push.entry = make_entry(OP_POLL, 1'b1, {CHAR_DIGIT_HI, stack_ff[0]},
                                         PAUSE_NONE, cnt_ff == 3'd1);
               for (int i = 0; i < DIGITS - 1; i++) begin
                  stack_in[i] = stack_ff[i+1];
               end
               stack_in[DIGITS-1] = 4'h0;
               cnt_in = cnt_ff - 3'd1;
               if (cnt_ff == 3'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         disp_ff  <= 3'd0;
         cnt_ff   <= 3'd0;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         disp_ff  <= disp_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      for (int i = 0; i < DIGITS; i++) begin
         stack_ff[i] <= stack_in[i];
      end
   end

endmodule
`default_nettype wire

FILE: design/clcd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD sequencer entry queue
// Short queue of byte entries between the front end and the bus sequencer.
// ----------------------------------------------------------------------------
module clcd_fifo
   import clcd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_push_type q_push,
   input  wire logic       q_pop,
   output q_status_type    q_status,
   output entry_type       q_head
);

   entry_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign q_status.full  = (count_ff == (QPTR_W + 1)'(QDEPTH));
   assign q_status.empty = (count_ff == '0);
   assign q_head         = mem_ff[rd_ptr_ff];

   assign do_push  = q_push.valid && !q_status.full;
   assign do_pop   = q_pop && !q_status.empty;
   assign count_in = count_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule
`default_nettype wire

FILE: design/clcd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD sequencer bus back end
// Expands each byte entry into a status poll (poll entries only) and one or two
// nibble writes and holds the current transfer in an output register.
// ----------------------------------------------------------------------------
module clcd_back
   import clcd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire q_status_type q_status,
   input  wire entry_type    q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_kind,
   output logic              rsp_reg_select,
   output logic [3:0]        rsp_nibble,
   output logic [19:0]       rsp_pause_cycles,
   output logic              rsp_last
);

   logic [1:0]  phase_ff, phase_in;
   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic        rs_ff, rs_in;
   logic [3:0]  nibble_ff, nibble_in;
   logic [19:0] pause_ff, pause_in;
   logic        last_ff, last_in;

   logic [1:0]  start;
   logic [1:0]  eff;
   logic        final_item;
   logic        load;

   always_comb begin
      unique case (q_head.op)
         OP_POLL: start = 2'd0;
         OP_BARE: start = 2'd1;
         default: start = 2'd2;
      endcase
   end

   assign eff        = phase_ff + start;
   assign final_item = (eff == 2'd2);
   assign load       = !q_status.empty && (!valid_ff || rsp_ready);
   assign q_pop      = load && final_item;

   always_comb begin
      valid_in  = valid_ff && !rsp_ready;
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      rs_in     = rs_ff;
      nibble_in = nibble_ff;
      pause_in  = pause_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = final_item ? 2'd0 : phase_ff + 2'd1;
         last_in  = final_item && q_head.last;
         if (eff == 2'd0) begin
            kind_in   = KIND_POLL;
            rs_in     = 1'b0;
            nibble_in = 4'h0;
            pause_in  = 20'd0;
         end else begin
            kind_in   = KIND_WRITE;
            rs_in     = q_head.rs;
            nibble_in = (eff == 2'd1) ? q_head.data[7:4] : q_head.data[3:0];
            pause_in  = ((eff == 2'd1) || (q_head.op == OP_NIB)) ?
                        pause_value(q_head.pause_sel) : 20'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      rs_ff     <= rs_in;
      nibble_ff <= nibble_in;
      pause_ff  <= pause_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_reg_select   = rs_ff;
   assign rsp_nibble       = nibble_ff;
   assign rsp_pause_cycles = pause_ff;
   assign rsp_last         = last_ff;

   // A status poll always addresses the instruction register with no data.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_POLL) |-> (!rs_ff && nibble_ff == 4'h0 && pause_ff == 20'd0))
      else $error("poll transfer carries data");

   // Only the final transfer of an entry can close a request.
   assert property (@(posedge clock) disable iff (reset)
      (load && !final_item) |=> (valid_ff && !last_ff))
      else $error("last flag set inside an entry");

   // The phase counter never runs past the final transfer of an entry.
   assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (phase_ff + start <= 2'd2))
      else $error("phase counter out of range");

endmodule
`default_nettype wire
